/* design/psat_pkg.sv */
// Shared types and constants for the separating-axis test.
package psat_pkg;

  localparam int MaxVerticesDefault = 16;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusEmptyB   = 2'd2;

  typedef struct packed {
    logic               polygon_select;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
    logic [30:0]        start_depth;
    logic signed [31:0] start_axis_x;
    logic signed [31:0] start_axis_y;
  } in_word_t;

  typedef struct packed {
    logic               collides;
    logic               axis_updated;
    logic [30:0]        depth;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic [1:0]         status;
  } out_word_t;

  // Projection request broadcast down the cell chain.
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } proj_cmd_t;

  // Running extremes carried from cell to cell.
  typedef struct packed {
    logic               valid;
    logic signed [65:0] lo;
    logic signed [65:0] hi;
  } proj_acc_t;

endpackage

/* design/polygon_separating_axis_test_top.sv */
// Top level of the separating-axis test: vertex loading, edge sequencing and result.
// Loading accepts one vertex per cycle while in the load state; in_stall is high otherwise.
// A test then handles each edge of A in turn: scaling, squaring, root, division and output
// in the normal unit, then sequencing, projection down the cell chains and the check; a
// zero-length edge skips the normal unit and goes straight on to the next edge.
// The result word is registered after the test and is held until taken; no vertex is
// taken while a test runs. Reset (rst, synchronous) clears counts, overflow flag and control.
module polygon_separating_axis_test_top #(
  parameter int MAX_VERTICES = psat_pkg::MaxVerticesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  psat_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psat_pkg::out_word_t out_data
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SEdge  = 3'd1;
  localparam logic [2:0] SNorm  = 3'd2;
  localparam logic [2:0] SProj  = 3'd3;
  localparam logic [2:0] SCheck = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]  state;
  logic [CW-1:0] count_a, count_b;
  logic        overflow_seen;
  logic        acc;
  logic [IW-1:0] edge_i;
  logic [CW-1:0] wait_cnt;

  // Edge end points are kept in a small memory copy of polygon A.
  logic signed [31:0] mem_x [MAX_VERTICES];
  logic signed [31:0] mem_y [MAX_VERTICES];
  logic signed [31:0] cur_x, cur_y, nxt_x, nxt_y;
  logic [IW-1:0] nxt_i;

  logic [61:0] best46;
  logic [30:0] cur_depth;
  logic signed [31:0] best_x, best_y;
  logic        updated;
  logic        collide_flag;
  logic [1:0]  status_code;

  logic        norm_start, norm_go, norm_done;
  logic signed [31:0] nx, ny;
  logic signed [32:0] ex, ey;

  psat_pkg::proj_cmd_t cmd;
  psat_pkg::proj_acc_t res_a, res_b;
  logic signed [65:0] top, bot;
  logic [65:0] ov;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state != SLoad);

  always_ff @(posedge clk) begin
    if (acc && !in_data.polygon_select && (count_a < CW'(MAX_VERTICES))) begin
      mem_x[count_a[IW-1:0]] <= in_data.vertex_x;
      mem_y[count_a[IW-1:0]] <= in_data.vertex_y;
    end
    cur_x <= mem_x[edge_i];
    cur_y <= mem_y[edge_i];
    nxt_x <= mem_x[nxt_i];
    nxt_y <= mem_y[nxt_i];
  end

  assign nxt_i = (CW'(edge_i) + CW'(1) == count_a) ? '0 : IW'(CW'(edge_i) + CW'(1));
  assign ex = 33'(nxt_x) - 33'(cur_x);
  assign ey = 33'(nxt_y) - 33'(cur_y);

  // A zero-length edge never reaches the normal unit.
  assign norm_go = norm_start && ((ex != '0) || (ey != '0));

  psat_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_go),
    .ex   (ex),
    .ey   (ey),
    .done (norm_done),
    .nx   (nx),
    .ny   (ny)
  );

  psat_chain #(.MAX_VERTICES(MAX_VERTICES)) u_chain_a (
    .clk(clk), .rst(rst),
    .wr(acc && !in_data.polygon_select && (count_a < CW'(MAX_VERTICES))),
    .wr_idx(count_a[IW-1:0]), .wx(in_data.vertex_x), .wy(in_data.vertex_y),
    .count(count_a), .cmd(cmd), .result(res_a)
  );

  psat_chain #(.MAX_VERTICES(MAX_VERTICES)) u_chain_b (
    .clk(clk), .rst(rst),
    .wr(acc && in_data.polygon_select && (count_b < CW'(MAX_VERTICES))),
    .wr_idx(count_b[IW-1:0]), .wx(in_data.vertex_x), .wy(in_data.vertex_y),
    .count(count_b), .cmd(cmd), .result(res_b)
  );

  assign top = (res_a.hi < res_b.hi) ? res_a.hi : res_b.hi;
  assign bot = (res_a.lo > res_b.lo) ? res_a.lo : res_b.lo;
  assign ov  = 66'(top - bot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SLoad;
      count_a <= '0;
      count_b <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      norm_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        SLoad: begin
          if (acc) begin
            logic [CW-1:0] na, nb;
            logic          of;
            na = count_a;
            nb = count_b;
            of = overflow_seen;
            if (in_data.polygon_select) begin
              if (count_b < CW'(MAX_VERTICES)) nb = count_b + CW'(1);
              else of = 1'b1;
            end else begin
              if (count_a < CW'(MAX_VERTICES)) na = count_a + CW'(1);
              else of = 1'b1;
            end
            count_a <= na;
            count_b <= nb;
            overflow_seen <= of;
            if (in_data.last_vertex) begin
              cur_depth <= in_data.start_depth;
              best46 <= {in_data.start_depth, 31'd0} >> 1;
              best_x <= in_data.start_axis_x;
              best_y <= in_data.start_axis_y;
              updated <= 1'b0;
              edge_i <= '0;
              collide_flag <= 1'b0;
              status_code <= psat_pkg::StatusOk;
              if (of) begin
                status_code <= psat_pkg::StatusOverflow;
                state <= SDone;
              end else if (nb == '0) begin
                status_code <= psat_pkg::StatusEmptyB;
                state <= SDone;
              end else begin
                collide_flag <= 1'b1;
                state <= (na == '0) ? SDone : SEdge;
              end
            end
          end
        end
        SEdge: begin
          // The end points are read at the end of this cycle and are steady from the next.
          wait_cnt <= '0;
          state <= SNorm;
          norm_start <= 1'b1;
        end
        SNorm: begin
          if (norm_start) begin
            if (ex == '0 && ey == '0) begin
              state <= SCheck;
              wait_cnt <= CW'(MAX_VERTICES);
            end
          end else if (norm_done) begin
            cmd.nx <= nx;
            cmd.ny <= ny;
            wait_cnt <= '0;
            state <= SProj;
          end
        end
        SProj: begin
          // The products are registered and then the cells hand the extremes on, one register per cell.
          wait_cnt <= wait_cnt + CW'(1);
          if (wait_cnt == CW'(MAX_VERTICES)) begin
            wait_cnt <= '0;
            state <= SCheck;
          end
        end
        SCheck: begin
          if (wait_cnt != CW'(MAX_VERTICES)) begin
            if ((res_a.hi < res_b.lo) || (res_b.hi < res_a.lo)) begin
              collide_flag <= 1'b0;
              state <= SDone;
            end else begin
              if (ov < 66'(best46)) begin
                best46 <= 62'(ov);
                cur_depth <= (ov[65:30] > 36'h07FFFFFFF) ? 31'h7FFFFFFF : ov[60:30];
                best_x <= cmd.nx;
                best_y <= cmd.ny;
                updated <= 1'b1;
              end
            end
          end
          if (state == SCheck) begin
            if (CW'(edge_i) + CW'(1) == count_a) begin
              state <= SDone;
            end else begin
              edge_i <= edge_i + IW'(1);
              state <= SEdge;
            end
          end
          if ((wait_cnt != CW'(MAX_VERTICES)) &&
              ((res_a.hi < res_b.lo) || (res_b.hi < res_a.lo))) begin
            state <= SDone;
          end
        end
        SDone: begin
          // The result waits here while the previous word is still unclaimed.
          if (!out_valid || !out_stall) begin
            out_data.collides <= collide_flag;
            out_data.axis_updated <= updated;
            out_data.depth <= cur_depth;
            out_data.axis_x <= best_x;
            out_data.axis_y <= best_y;
            out_data.status <= status_code;
            out_valid <= 1'b1;
            count_a <= '0;
            count_b <= '0;
            overflow_seen <= 1'b0;
            state <= SLoad;
          end
        end
        default: state <= SLoad;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != SLoad) |-> !acc;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("vertex taken during test");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(MAX_VERTICES)) && (count_b <= CW'(MAX_VERTICES)))
    else $error("vertex count beyond store");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == SDone) && (!out_valid || !out_stall)) |=>
      (count_a == '0) && (count_b == '0) && out_valid)
    else $error("result without clearing the stores");

endmodule

/* design/psat_cell.sv */
// One cell of the vertex chain: holds a vertex and folds its projection into the extremes.
module psat_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic signed [31:0]           wx,
  input  logic signed [31:0]           wy,
  input  logic                         en,
  input  psat_pkg::proj_cmd_t          cmd,
  input  psat_pkg::proj_acc_t          acc_in,
  output psat_pkg::proj_acc_t          acc_out
);

  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [65:0] dot;
  psat_pkg::proj_acc_t acc_next;

  always_ff @(posedge clk) begin
    if (wr) begin
      vx <= wx;
      vy <= wy;
    end
  end

  // The products are registered before they are summed and compared.
  always_ff @(posedge clk) begin
    px <= vx * cmd.nx;
    py <= vy * cmd.ny;
  end

  always_comb begin
    dot = 66'(px) + 66'(py);
    acc_next = acc_in;
    if (en) begin
      if (!acc_in.valid) begin
        acc_next.valid = 1'b1;
        acc_next.lo = dot;
        acc_next.hi = dot;
      end else begin
        if (dot < acc_in.lo) acc_next.lo = dot;
        if (dot > acc_in.hi) acc_next.hi = dot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.valid <= 1'b0;
    end else begin
      acc_out.valid <= acc_next.valid;
    end
    acc_out.lo <= acc_next.lo;
    acc_out.hi <= acc_next.hi;
  end

endmodule

/* design/psat_chain.sv */
// A row of vertex cells for one polygon, giving min and max projections.
module psat_chain #(
  parameter int MAX_VERTICES = psat_pkg::MaxVerticesDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr,
  input  logic [$clog2(MAX_VERTICES)-1:0]  wr_idx,
  input  logic signed [31:0]               wx,
  input  logic signed [31:0]               wy,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] count,
  input  psat_pkg::proj_cmd_t              cmd,
  output psat_pkg::proj_acc_t              result
);

  psat_pkg::proj_acc_t acc [MAX_VERTICES+1];

  assign acc[0] = '{valid: 1'b0, lo: '0, hi: '0};

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic en;
    assign en = ($clog2(MAX_VERTICES+1))'(g) < count;
    psat_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr && (wr_idx == ($clog2(MAX_VERTICES))'(g))),
      .wx     (wx),
      .wy     (wy),
      .en     (en),
      .cmd    (cmd),
      .acc_in (acc[g]),
      .acc_out(acc[g+1])
    );
  end

  assign result = acc[MAX_VERTICES];

endmodule

/* design/psat_norm.sv */
// Edge normal unit: normalises the perpendicular of an edge to a Q2.30 unit vector.
module psat_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] ex,
  input  logic signed [32:0] ey,
  output logic               done,
  output logic signed [31:0] nx,
  output logic signed [31:0] ny
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScale = 3'd1;
  localparam logic [2:0] SSq    = 3'd2;
  localparam logic [2:0] SSqrt  = 3'd3;
  localparam logic [2:0] SDiv   = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0]  state;
  logic [32:0] ux, uy;
  logic        neg_x, neg_y;
  logic [63:0] sq;
  logic [63:0] rem;
  logic [31:0] root;
  logic [5:0]  cnt;
  logic [62:0] dnum;
  logic [31:0] len;
  logic [31:0] q;
  logic [62:0] drem;
  logic        div_y;
  logic [31:0] qx;
  logic [32:0] m;

  assign m = (ux > uy) ? ux : uy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SIdle: begin
          if (start) begin
            ux <= ey[32] ? 33'(-ey) : 33'(ey);
            uy <= ex[32] ? 33'(-ex) : 33'(ex);
            neg_x <= ~ey[32] && (ey != '0);
            neg_y <= ex[32];
            state <= SScale;
          end
        end
        SScale: begin
          // One shift per cycle until the larger magnitude sits in [2^30, 2^31).
          if (m[32:31] != 2'b00) begin
            ux <= ux >> 1;
            uy <= uy >> 1;
          end else if (!m[30]) begin
            ux <= ux << 1;
            uy <= uy << 1;
          end else begin
            state <= SSq;
          end
        end
        SSq: begin
          sq <= 64'(ux[31:0]) * 64'(ux[31:0]) + 64'(uy[31:0]) * 64'(uy[31:0]);
          rem <= '0;
          root <= '0;
          cnt <= 6'd32;
          state <= SSqrt;
        end
        SSqrt: begin
          // Bit-pair restoring square root, one result bit per cycle.
          if ({rem[61:0], sq[63:62]} >= {root, 2'b01}) begin
            rem <= {rem[61:0], sq[63:62]} - 64'({root, 2'b01});
            root <= {root[30:0], 1'b1};
          end else begin
            rem <= {rem[61:0], sq[63:62]};
            root <= {root[30:0], 1'b0};
          end
          sq <= {sq[61:0], 2'b00};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= SDiv;
            div_y <= 1'b0;
          end
        end
        SDiv: begin
          if (cnt == 6'd0) begin
            len <= root;
            dnum <= {ux[31:0], 30'd0} + 63'(root >> 1);
            drem <= '0;
            q <= '0;
            cnt <= 6'd63;
          end else begin
            // Restoring division, one quotient bit per cycle.
            if ({drem[61:0], dnum[62]} >= 63'(len)) begin
              drem <= {drem[61:0], dnum[62]} - 63'(len);
              q <= {q[30:0], 1'b1};
            end else begin
              drem <= {drem[61:0], dnum[62]};
              q <= {q[30:0], 1'b0};
            end
            dnum <= {dnum[61:0], 1'b0};
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) begin
              if (!div_y) begin
                qx <= {q[30:0], ({drem[61:0], dnum[62]} >= 63'(len))};
                div_y <= 1'b1;
                len <= len;
                dnum <= {uy[31:0], 30'd0} + 63'(len >> 1);
                drem <= '0;
                q <= '0;
                cnt <= 6'd63;
              end else begin
                state <= SOut;
              end
            end
          end
        end
        SOut: begin
          nx <= neg_x ? -qx : qx;
          ny <= neg_y ? -q : q;
          done <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

/* tb/sv/psat_checker.sv */
// Checker for the separating-axis test: watches both channels, predicts results and compares.
`timescale 1ns / 1ps
module psat_checker #(
  parameter int MAX_VERTICES = psat_pkg::MaxVerticesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  psat_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  psat_pkg::out_word_t out_data,
  output int                  failures,
  output int                  pending,
  output int                  results_seen
);

  int a_x[MAX_VERTICES];
  int a_y[MAX_VERTICES];
  int b_x[MAX_VERTICES];
  int b_y[MAX_VERTICES];
  int cnt_a;
  int cnt_b;
  bit store_overflow;
  psat_pkg::out_word_t expected_results[$];

  assign pending = expected_results.size();

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Extremes of one polygon projected onto the normal (nx, ny).
  function automatic void span_on_axis(input bit of_b, input longint nx, input longint ny,
                                       output longint lo, output longint hi);
    longint d;
    int n;
    n = of_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      if (of_b) d = longint'(b_x[i]) * nx + longint'(b_y[i]) * ny;
      else d = longint'(a_x[i]) * nx + longint'(a_y[i]) * ny;
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  function automatic psat_pkg::out_word_t run_axis_test(input psat_pkg::in_word_t w);
    psat_pkg::out_word_t r;
    longint unsigned best46, ux, uy, m, len, qx, qy, ov, deep;
    longint ex, ey, nx, ny, lo_a, hi_a, lo_b, hi_b, top, bot;
    int j;
    r.collides = 1'b1;
    r.axis_updated = 1'b0;
    r.depth = w.start_depth;
    r.axis_x = w.start_axis_x;
    r.axis_y = w.start_axis_y;
    r.status = psat_pkg::StatusOk;
    if (store_overflow) begin
      r.status = psat_pkg::StatusOverflow;
      r.collides = 1'b0;
    end else if (cnt_b == 0) begin
      r.status = psat_pkg::StatusEmptyB;
      r.collides = 1'b0;
    end else begin
      best46 = longint'(w.start_depth) << 30;
      for (int i = 0; i < cnt_a; i++) begin
        j = (i + 1 == cnt_a) ? 0 : i + 1;
        ex = longint'(a_x[j]) - longint'(a_x[i]);
        ey = longint'(a_y[j]) - longint'(a_y[i]);
        if (ex == 0 && ey == 0) continue;
        ux = (ex < 0) ? -ex : ex;
        uy = (ey < 0) ? -ey : ey;
        m = (ux > uy) ? ux : uy;
        while (m >= (64'd1 << 31)) begin
          ux = ux >> 1; uy = uy >> 1; m = m >> 1;
        end
        while (m < (64'd1 << 30)) begin
          ux = ux << 1; uy = uy << 1; m = m << 1;
        end
        len = int_root(ux * ux + uy * uy);
        qx = ((uy << 30) + (len >> 1)) / len;
        qy = ((ux << 30) + (len >> 1)) / len;
        nx = (ey > 0) ? -longint'(qx) : longint'(qx);
        ny = (ex < 0) ? -longint'(qy) : longint'(qy);
        span_on_axis(1'b0, nx, ny, lo_a, hi_a);
        span_on_axis(1'b1, nx, ny, lo_b, hi_b);
        if (hi_a < lo_b || hi_b < lo_a) begin
          r.collides = 1'b0;
          break;
        end
        top = (hi_a < hi_b) ? hi_a : hi_b;
        bot = (lo_a > lo_b) ? lo_a : lo_b;
        ov = top - bot;
        if (ov < best46) begin
          best46 = ov;
          deep = ov >> 30;
          r.depth = (deep > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : deep[30:0];
          r.axis_x = nx[31:0];
          r.axis_y = ny[31:0];
          r.axis_updated = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cnt_a <= 0;
      cnt_b <= 0;
      store_overflow <= 1'b0;
      expected_results.delete();
      failures <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.polygon_select) begin
          if (cnt_b < MAX_VERTICES) begin
            b_x[cnt_b] = in_data.vertex_x;
            b_y[cnt_b] = in_data.vertex_y;
            cnt_b = cnt_b + 1;
          end else begin
            store_overflow = 1'b1;
          end
        end else if (cnt_a < MAX_VERTICES) begin
          a_x[cnt_a] = in_data.vertex_x;
          a_y[cnt_a] = in_data.vertex_y;
          cnt_a = cnt_a + 1;
        end else begin
          store_overflow = 1'b1;
        end
        if (in_data.last_vertex) begin
          expected_results.push_back(run_axis_test(in_data));
          cnt_a = 0;
          cnt_b = 0;
          store_overflow = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_data);
          failures <= failures + 1;
        end else if (expected_results[0] !== out_data) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time,
                   expected_results[0], out_data);
          failures <= failures + 1;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the separating-axis testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int WatchdogLimit = 40000;
  localparam int LongHoldCycles = 6000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  psat_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  psat_pkg::out_word_t out_data;
  int        failures;
  int        pending;
  int        results_seen;

  int  words_sent;
  int  quiet_cycles;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_req;
  psat_pkg::in_word_t burst[$];

  polygon_separating_axis_test_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  psat_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .failures(failures), .pending(pending), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("polygon_separating_axis_test_top test failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  function automatic psat_pkg::in_word_t vertex_word(input bit sel, input int x, input int y);
    psat_pkg::in_word_t w;
    w.polygon_select = sel;
    w.vertex_x = x;
    w.vertex_y = y;
    w.last_vertex = 1'b0;
    w.start_depth = 31'($urandom());
    w.start_axis_x = $urandom();
    w.start_axis_y = $urandom();
    return w;
  endfunction

  function automatic int rand_axis_part();
    return int'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
  endfunction

  // Offers one word and returns once it has been taken.
  task automatic send_word(input psat_pkg::in_word_t w);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Sends the queued vertices, marking the final one with the start values.
  task automatic send_test(input int depth, input int axx, input int axy);
    burst[burst.size() - 1].last_vertex = 1'b1;
    burst[burst.size() - 1].start_depth = depth[30:0];
    burst[burst.size() - 1].start_axis_x = axx;
    burst[burst.size() - 1].start_axis_y = axy;
    foreach (burst[i]) send_word(burst[i]);
    burst.delete();
  endtask

  task automatic add_square(input bit sel, input int x0, input int y0, input int side);
    burst.push_back(vertex_word(sel, x0, y0));
    burst.push_back(vertex_word(sel, x0 + side, y0));
    burst.push_back(vertex_word(sel, x0 + side, y0 + side));
    burst.push_back(vertex_word(sel, x0, y0 + side));
  endtask

  // Roughly regular polygon around a centre, coordinates in Q16.16.
  task automatic add_polygon(input bit sel, input real cx, input real cy, input real rad,
                             input int n);
    real ang;
    real ph;
    ph = $urandom_range(0, 628) / 100.0;
    for (int i = 0; i < n; i++) begin
      ang = ph + 6.2831853 * i / n;
      burst.push_back(vertex_word(sel, int'((cx + rad * $cos(ang)) * 65536.0),
                                  int'((cy + rad * $sin(ang)) * 65536.0)));
    end
  endtask

  function automatic real rand_coord(input real span);
    return ($urandom_range(0, 20000) / 10000.0 - 1.0) * span;
  endfunction

  task automatic random_test();
    int kind;
    real span;
    real rad;
    kind = $urandom_range(0, 99);
    span = (kind % 3 == 0) ? 20000.0 : ((kind % 3 == 1) ? 50.0 : 0.5);
    rad = span * ($urandom_range(1, 100) / 200.0);
    if (kind < 78) begin
      add_polygon(1'b0, rand_coord(span), rand_coord(span), rad, $urandom_range(2, 6));
      add_polygon(1'b1, rand_coord(span), rand_coord(span), rad, $urandom_range(1, 6));
      if ($urandom_range(0, 1)) burst.reverse();
      send_test($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20), rand_axis_part(),
                rand_axis_part());
    end else if (kind < 88) begin
      // Noise: fully random vertices, the test starting now and then.
      repeat ($urandom_range(1, 6)) begin
        burst.push_back(vertex_word(1'($urandom_range(0, 1)), $urandom(), $urandom()));
        if ($urandom_range(0, 5) == 0) send_test($urandom(), rand_axis_part(),
                                                 rand_axis_part());
      end
      if (burst.size() != 0) send_test($urandom(), rand_axis_part(), rand_axis_part());
    end else if (kind < 93) begin
      add_polygon(1'b0, 0.0, 0.0, rad, $urandom_range(17, 20));
      add_polygon(1'b1, 0.0, 0.0, rad, 3);
      send_test($urandom(), rand_axis_part(), rand_axis_part());
    end else if (kind < 97) begin
      add_polygon(1'b0, 0.0, 0.0, rad, $urandom_range(0, 1) ? 4 : 1);
      if (kind == 96) add_polygon(1'b1, 0.0, 0.0, rad, 3);
      if (burst.size() < 4) add_polygon(1'b0, 1.0, 0.0, rad, 1);
      send_test($urandom(), rand_axis_part(), rand_axis_part());
    end else begin
      add_polygon(1'b1, 0.0, 0.0, rad, 3);
      send_test($urandom(), rand_axis_part(), rand_axis_part());
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Overlapping squares, then separated squares.
    add_square(1'b0, 0, 0, 32'h2_0000);
    add_square(1'b1, 32'h1_0000, 32'h1_0000, 32'h2_0000);
    send_test(32'h7FFF_FFFF, 32'h4000_0000, 0);
    add_square(1'b0, 0, 0, 32'h1_0000);
    add_square(1'b1, 32'h5_0000, 0, 32'h1_0000);
    send_test(0, -32'sh4000_0000, 0);
    // Touching edges, with a repeated vertex giving a zero-length edge.
    add_square(1'b0, 0, 0, 32'h1_0000);
    burst.push_back(vertex_word(1'b0, 0, 32'h1_0000));
    add_square(1'b1, 32'h1_0000, 0, 32'h1_0000);
    send_test(32'h7FFF_FFFF, 0, -32'sh4000_0000);
    // Extreme coordinates, and a single vertex of A.
    burst.push_back(vertex_word(1'b0, 32'sh8000_0000, 32'sh8000_0000));
    burst.push_back(vertex_word(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000));
    burst.push_back(vertex_word(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    burst.push_back(vertex_word(1'b1, 0, 0));
    burst.push_back(vertex_word(1'b1, -1, -1));
    send_test(32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000);
    burst.push_back(vertex_word(1'b0, 5, 5));
    burst.push_back(vertex_word(1'b1, 5, 5));
    send_test(1234, 0, 32'h4000_0000);
    // Empty B, and B only (no A at all).
    add_square(1'b0, 0, 0, 32'h1_0000);
    send_test(77, 0, 0);
    burst.push_back(vertex_word(1'b1, 3, 4));
    send_test(0, 0, 0);

    while (words_sent < 250) random_test();
    // Let the block drain completely, then hold the output for a long stretch.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    hold_req = 1'b1;
    while (words_sent < 650) random_test();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (words_sent < 760) random_test();
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d vertex words and checked %0d test results,", words_sent, results_seen);
    $display("covering overflow, empty B, single-vertex A, touching and separated cases.");
    if (failures == 0 && pending == 0) begin
      $display("polygon_separating_axis_test_top test passed");
    end else begin
      $display("polygon_separating_axis_test_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/psat_pkg.sv
design/psat_cell.sv
design/psat_chain.sv
design/psat_norm.sv
design/polygon_separating_axis_test_top.sv
tb/sv/psat_checker.sv
tb/sv/testbench.sv
